// File: hw/rtl/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ChW      = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ErrLineW = 24;
  localparam int unsigned ErrColW  = 16;

  localparam logic [CmdW-1:0] CMD_CHAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_EOL  = 2'd1;
  localparam logic [CmdW-1:0] CMD_EOF  = 2'd2;

  localparam logic [KindW-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_EOL   = 2'd1;
  localparam logic [KindW-1:0] KIND_EOF   = 2'd2;
  localparam logic [KindW-1:0] KIND_UNCLOSED = 2'd3;

  localparam logic [ChW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ChW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ChW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ChW-1:0] CH_QUOTE  = 8'h22;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [ChW-1:0]      out_char;
    logic [ErrLineW-1:0] err_line;
    logic [ErrColW-1:0]  err_col;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ccs_in_if.sv
`default_nettype none

interface ccs_in_if;
  import ccs_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [ChW-1:0]  ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ccs_out_if.sv
`default_nettype none

interface ccs_out_if;
  import ccs_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [ChW-1:0]      out_char;
  logic [ErrLineW-1:0] err_line;
  logic [ErrColW-1:0]  err_col;
  logic                last;

  modport source (output valid, output kind, output out_char, output err_line,
                  output err_col, output last, input ready);
  modport sink   (input valid, input kind, input out_char, input err_line,
                  input err_col, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/c_comment_stripper.sv
`default_nettype none

// Channel  Direction  Fields
// in_i     input      cmd, ch
// out_o    output     kind, out_char, err_line, err_col, last
//
// An input transfer is registered, then decoded combinationally into zero, one or
// two results that are written into a four-entry output queue.
// One input item is taken per cycle; in_i.ready drops only while the queue has
// fewer than two free entries and the input register is full.
// Each result passes through the input register and the output queue before out_o.
// rst_ni clears all stream state and empties the queue; end of file also
// returns the stream state to its reset values.
module c_comment_stripper #(
  parameter int unsigned LINE_COUNT_BITS = 24,
  parameter int unsigned COL_BITS        = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ccs_in_if.sink      in_i,
  ccs_out_if.source   out_o
);
  import ccs_pkg::*;

  typedef struct packed {
    logic                       in_block;
    logic                       star_seen;
    logic                       in_line_comment;
    logic                       next_line_comment;
    logic                       last_was_backslash;
    logic                       in_quote;
    logic                       escaped;
    logic                       slash_held;
    logic [LINE_COUNT_BITS-1:0] line_count;
    logic [COL_BITS-1:0]        kept_count;
    logic [LINE_COUNT_BITS-1:0] open_line;
    logic [COL_BITS-1:0]        open_col;
  } st_t;

  localparam logic [LINE_COUNT_BITS-1:0] LineMax = {LINE_COUNT_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]        ColMax  = {COL_BITS{1'b1}};

  localparam st_t StReset = '{
    in_block: 1'b0, star_seen: 1'b0, in_line_comment: 1'b0,
    next_line_comment: 1'b0, last_was_backslash: 1'b0, in_quote: 1'b0,
    escaped: 1'b0, slash_held: 1'b0,
    line_count: LINE_COUNT_BITS'(1), kept_count: '0,
    open_line: '0, open_col: '0
  };

  logic            in_valid_q;
  logic [CmdW-1:0] cmd_q;
  logic [ChW-1:0]  ch_q;

  st_t st_q, st_d;
  res_t res [2];
  logic [1:0] res_n;

  res_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   count_q, count_d;
  logic                proc;
  logic                pop;

  assign proc       = in_valid_q && (count_q <= (FifoPtrW + 1)'(FifoDepth - 2));
  assign in_i.ready = !in_valid_q || proc;
  assign pop        = out_o.valid && out_o.ready;

  always_comb begin
    logic [COL_BITS-1:0] col_inc;
    st_d  = st_q;
    res[0] = '0;
    res[1] = '0;
    res_n = 2'd0;
    col_inc = '0;
    unique case (cmd_q)
      CMD_CHAR: begin
        if (st_q.next_line_comment || st_q.in_line_comment) begin
          st_d.kept_count = st_q.kept_count;
        end else if (st_q.in_block) begin
          if (st_q.star_seen && ch_q == CH_SLASH) begin
            st_d.in_block  = 1'b0;
            st_d.star_seen = 1'b0;
          end else begin
            st_d.star_seen = (ch_q == CH_STAR);
          end
        end else if (st_q.in_quote) begin
          if (st_q.escaped) begin
            st_d.escaped = 1'b0;
          end else if (ch_q == CH_BSLASH) begin
            st_d.escaped = 1'b1;
          end else if (ch_q == CH_QUOTE) begin
            st_d.in_quote = 1'b0;
          end
          res[res_n[0]].kind     = KIND_CHAR;
          res[res_n[0]].out_char = ch_q;
          res_n = res_n + 2'd1;
          if (st_d.kept_count != ColMax) st_d.kept_count = st_d.kept_count + 1'b1;
        end else begin
          if (st_q.slash_held) begin
            st_d.slash_held = 1'b0;
          end
          if (st_q.slash_held && ch_q == CH_STAR) begin
            st_d.in_block  = 1'b1;
            st_d.star_seen = 1'b1;
            st_d.open_line = st_q.line_count;
            st_d.open_col  = st_q.kept_count;
          end else if (st_q.slash_held && ch_q == CH_SLASH) begin
            st_d.in_line_comment = 1'b1;
          end else begin
            if (st_q.slash_held) begin
              res[res_n[0]].kind     = KIND_CHAR;
              res[res_n[0]].out_char = CH_SLASH;
              res_n = res_n + 2'd1;
              if (st_d.kept_count != ColMax) st_d.kept_count = st_d.kept_count + 1'b1;
            end
            if (ch_q == CH_SLASH) begin
              st_d.slash_held = 1'b1;
            end else begin
              if (ch_q == CH_QUOTE) begin
                st_d.in_quote = 1'b1;
                st_d.escaped  = 1'b0;
              end
              res[res_n[0]].kind     = KIND_CHAR;
              res[res_n[0]].out_char = ch_q;
              res_n = res_n + 2'd1;
              if (st_d.kept_count != ColMax) st_d.kept_count = st_d.kept_count + 1'b1;
            end
          end
        end
        st_d.last_was_backslash = (ch_q == CH_BSLASH);
      end
      CMD_EOL: begin
        if (st_q.slash_held) begin
          res[res_n[0]].kind     = KIND_CHAR;
          res[res_n[0]].out_char = CH_SLASH;
          res_n = res_n + 2'd1;
        end
        st_d.next_line_comment = (st_q.next_line_comment || st_q.in_line_comment)
                                 && st_q.last_was_backslash;
        st_d.in_line_comment    = 1'b0;
        st_d.in_quote           = 1'b0;
        st_d.escaped            = 1'b0;
        st_d.slash_held         = 1'b0;
        st_d.star_seen          = 1'b0;
        st_d.last_was_backslash = 1'b0;
        st_d.kept_count         = '0;
        if (st_q.line_count != LineMax) st_d.line_count = st_q.line_count + 1'b1;
        res[res_n[0]].kind = KIND_EOL;
        res_n = res_n + 2'd1;
      end
      CMD_EOF: begin
        if (st_q.in_block) begin
          col_inc = (st_q.open_col != ColMax) ? st_q.open_col + 1'b1 : ColMax;
          res[res_n[0]].kind     = KIND_UNCLOSED;
          res[res_n[0]].err_line = ErrLineW'(st_q.open_line);
          res[res_n[0]].err_col  = ErrColW'(col_inc);
          res_n = res_n + 2'd1;
        end else begin
          if (st_q.slash_held) begin
            res[res_n[0]].kind     = KIND_CHAR;
            res[res_n[0]].out_char = CH_SLASH;
            res_n = res_n + 2'd1;
          end
          res[res_n[0]].kind = KIND_EOF;
          res_n = res_n + 2'd1;
        end
        st_d = StReset;
      end
      default: begin
        st_d = st_q;
      end
    endcase
    if (res_n != 2'd0) begin
      res[res_n[1]].last = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (proc) count_d = count_d + (FifoPtrW + 1)'(res_n);
    if (pop)  count_d = count_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= StReset;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        st_q     <= st_d;
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(res_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.cmd;
      ch_q  <= in_i.ch;
    end
    if (proc && res_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res[0];
    end
    if (proc && res_n == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= res[1];
    end
  end

  assign out_o.valid    = (count_q != '0);
  assign out_o.kind     = fifo_q[rd_ptr_q].kind;
  assign out_o.out_char = fifo_q[rd_ptr_q].out_char;
  assign out_o.err_line = fifo_q[rd_ptr_q].err_line;
  assign out_o.err_col  = fifo_q[rd_ptr_q].err_col;
  assign out_o.last     = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire
